// File: hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console cell writer.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package tcw_pkg;

    localparam int CHAR_W    = 8;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY   = 2'd2;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CHAR_W-1:0] BLANK_CHAR    = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR  = 8'd10;
    localparam logic [CHAR_W-1:0] RST_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] RST_ENTER     = 8'd13;

    typedef struct packed {
        logic              operation;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_item;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic rd_capture;
        logic clr_we;
        logic blank_we;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op_read;
        logic scroll;
        logic clr_last;
        logic blank_last;
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/tcw_ifs.sv
// Valid/ready channel interfaces: input words, result words and register writes.
// Depends on tcw_pkg for the field widths.
`default_nettype none

interface tcw_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic [tcw_pkg::ROW_W-1:0]   read_row;
    logic [tcw_pkg::COL_W-1:0]   read_col;

    modport source (output valid, operation, char_code, read_row, read_col, input ready);
    modport sink   (input valid, operation, char_code, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::COL_W-1:0]   cursor_col;
    logic [tcw_pkg::ROW_W-1:0]   cursor_row;
    logic                        scrolled;
    logic [tcw_pkg::CHAR_W-1:0]  read_char;

    modport source (output valid, cursor_col, cursor_row, scrolled, read_char, input ready);
    modport sink   (input valid, cursor_col, cursor_row, scrolled, read_char, output ready);
endinterface

interface tcw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CFG_IDX_W-1:0] index;
    logic [tcw_pkg::CHAR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/tcw_ctrl.sv
// Controller state machine: store clearing after reset, word sequencing,
// row blanking on a scroll and the output handshake. Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_ready,
    input  wire tcw_pkg::t_status i_status,
    output tcw_pkg::t_cmd         o_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_valid
);
    import tcw_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       w_cmd;

    always_comb begin
        n_state  = r_state;
        w_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr_we = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                w_cmd.exec = 1'b1;
                if (i_status.op_read) begin
                    n_state = S_RDWAIT;
                end else if (i_status.scroll) begin
                    n_state = S_BLANK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RDWAIT: begin
                w_cmd.rd_capture = 1'b1;
                n_state          = S_FIN;
            end
            S_BLANK: begin
                w_cmd.blank_we = 1'b1;
                if (i_status.blank_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // The result waits here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: hw/rtl/tcw_dp.sv
// Datapath: cursor, scroll origin, configuration registers, cell store and the
// result register. Depends on tcw_pkg and tcw_ram.
`default_nettype none

module tcw_dp #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tcw_pkg::t_cmd                i_cmd,
    output tcw_pkg::t_status                  o_status,
    input  wire tcw_pkg::t_item               i_item,
    input  wire logic                         i_cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tcw_pkg::CHAR_W-1:0]   i_cfg_data,
    output logic      [tcw_pkg::COL_W-1:0]    o_cursor_col,
    output logic      [tcw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic                              o_scrolled,
    output logic      [tcw_pkg::CHAR_W-1:0]   o_read_char
);
    import tcw_pkg::*;

    localparam int ROW_BITS = $clog2(ROWS);
    localparam int COL_BITS = $clog2(COLUMNS);
    localparam int DEPTH    = ROWS * COLUMNS;
    localparam int AW       = $clog2(DEPTH);

    function automatic logic [ROW_BITS-1:0] phys_row(input logic [ROW_BITS-1:0] top,
                                                     input logic [ROW_BITS-1:0] shown);
        logic [ROW_BITS:0] s;
        s = {1'b0, top} + {1'b0, shown};
        if (s >= (ROW_BITS+1)'(ROWS)) begin
            s = s - (ROW_BITS+1)'(ROWS);
        end
        return s[ROW_BITS-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [ROW_BITS-1:0] row,
                                                input logic [COL_BITS-1:0] col);
        return AW'(AW'(row) * AW'(COLUMNS)) + AW'(col);
    endfunction

    t_item               r_item, n_item;
    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [ROW_BITS-1:0] r_top, n_top;
    logic [CHAR_W-1:0]   r_bs, n_bs;
    logic [CHAR_W-1:0]   r_enter, n_enter;
    logic                r_disp, n_disp;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic [COL_BITS-1:0] r_blank_col, n_blank_col;
    logic                r_rd_ok, n_rd_ok;
    logic [CHAR_W-1:0]   r_res_rd, n_res_rd;
    logic                r_res_scrolled, n_res_scrolled;
    logic [COL_BITS-1:0] r_out_col, n_out_col;
    logic [ROW_BITS-1:0] r_out_row, n_out_row;
    logic                r_out_scrolled, n_out_scrolled;
    logic [CHAR_W-1:0]   r_out_rd, n_out_rd;

    logic                w_is_read;
    logic                w_is_bs;
    logic                w_is_nl;
    logic                w_is_print;
    logic [COL_BITS:0]   w_col_inc;
    logic                w_wrap;
    logic                w_line_feed;
    logic                w_at_last;
    logic                w_scroll;
    logic                w_in_range;
    logic                w_put_we;
    logic [AW-1:0]       w_cur_addr;
    logic [AW-1:0]       w_rd_addr;
    logic [AW-1:0]       w_blank_addr;
    logic                w_ram_we;
    logic [AW-1:0]       w_ram_waddr;
    logic [CHAR_W-1:0]   w_ram_wdata;
    logic                w_ram_re;
    logic [CHAR_W-1:0]   w_ram_rdata;

    // Decode of the held word; backspace is tested before newline and enter.
    always_comb begin
        w_is_read   = (r_item.operation == OP_READ);
        w_is_bs     = (r_item.char_code == r_bs);
        w_is_nl     = !w_is_bs && ((r_item.char_code == NEWLINE_CHAR) ||
                                   (r_item.char_code == r_enter));
        w_is_print  = !w_is_bs && !w_is_nl;
        w_col_inc   = {1'b0, r_col} + (COL_BITS+1)'(1);
        w_wrap      = w_is_print && (w_col_inc == (COL_BITS+1)'(COLUMNS));
        w_line_feed = w_is_nl || w_wrap;
        w_at_last   = (r_row == ROW_BITS'(ROWS - 1));
        w_scroll    = !w_is_read && w_line_feed && w_at_last && r_disp;
        w_in_range  = ({1'b0, r_item.read_row} < (ROW_W+1)'(ROWS)) &&
                      ({1'b0, r_item.read_col} < (COL_W+1)'(COLUMNS));
        w_put_we    = i_cmd.exec && !w_is_read && w_is_print;
        w_cur_addr  = cell_addr(phys_row(r_top, r_row), r_col);
        w_rd_addr   = cell_addr(phys_row(r_top, r_item.read_row[ROW_BITS-1:0]),
                                r_item.read_col[COL_BITS-1:0]);
        w_blank_addr = cell_addr(r_top, r_blank_col);
    end

    always_comb begin
        w_ram_we    = i_cmd.clr_we || i_cmd.blank_we || w_put_we;
        w_ram_re    = i_cmd.exec && w_is_read && w_in_range;
        if (i_cmd.clr_we) begin
            w_ram_waddr = r_clr_addr;
        end else if (i_cmd.blank_we) begin
            w_ram_waddr = w_blank_addr;
        end else begin
            w_ram_waddr = w_cur_addr;
        end
        w_ram_wdata = (i_cmd.clr_we || i_cmd.blank_we) ? BLANK_CHAR : r_item.char_code;
    end

    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_item         = r_item;
        n_col          = r_col;
        n_row          = r_row;
        n_top          = r_top;
        n_bs           = r_bs;
        n_enter        = r_enter;
        n_disp         = r_disp;
        n_clr_addr     = r_clr_addr;
        n_blank_col    = r_blank_col;
        n_rd_ok        = r_rd_ok;
        n_res_rd       = r_res_rd;
        n_res_scrolled = r_res_scrolled;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_out_scrolled = r_out_scrolled;
        n_out_rd       = r_out_rd;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BACKSPACE: n_bs    = i_cfg_data;
                CFG_ENTER:     n_enter = i_cfg_data;
                CFG_DISPLAY:   n_disp  = i_cfg_data[0];
                default:       ;
            endcase
        end

        if (i_cmd.load_in) begin
            n_item = i_item;
        end

        if (i_cmd.clr_we) begin
            n_clr_addr = r_clr_addr + AW'(1);
        end

        if (i_cmd.exec) begin
            n_rd_ok        = w_in_range;
            n_res_rd       = '0;
            n_res_scrolled = w_scroll;
            if (!w_is_read) begin
                if (w_is_bs) begin
                    if (r_col != '0) begin
                        n_col = r_col - COL_BITS'(1);
                    end
                end else if (w_line_feed) begin
                    n_col = '0;
                    if (!w_at_last) begin
                        n_row = r_row + ROW_BITS'(1);
                    end
                end else begin
                    n_col = w_col_inc[COL_BITS-1:0];
                end
            end
        end

        if (i_cmd.rd_capture) begin
            n_res_rd = r_rd_ok ? w_ram_rdata : '0;
        end

        // The old top row is blanked and then becomes the bottom row.
        if (i_cmd.blank_we) begin
            if (o_status.blank_last) begin
                n_blank_col = '0;
                n_top = (r_top == ROW_BITS'(ROWS - 1)) ? '0 : r_top + ROW_BITS'(1);
            end else begin
                n_blank_col = r_blank_col + COL_BITS'(1);
            end
        end

        if (i_cmd.out_load) begin
            n_out_col      = r_col;
            n_out_row      = r_row;
            n_out_scrolled = r_res_scrolled;
            n_out_rd       = r_res_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_top       <= '0;
            r_bs        <= RST_BACKSPACE;
            r_enter     <= RST_ENTER;
            r_disp      <= 1'b1;
            r_clr_addr  <= '0;
            r_blank_col <= '0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_top       <= n_top;
            r_bs        <= n_bs;
            r_enter     <= n_enter;
            r_disp      <= n_disp;
            r_clr_addr  <= n_clr_addr;
            r_blank_col <= n_blank_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item         <= n_item;
        r_rd_ok        <= n_rd_ok;
        r_res_rd       <= n_res_rd;
        r_res_scrolled <= n_res_scrolled;
        r_out_col      <= n_out_col;
        r_out_row      <= n_out_row;
        r_out_scrolled <= n_out_scrolled;
        r_out_rd       <= n_out_rd;
    end

    always_comb begin
        o_status.op_read    = w_is_read;
        o_status.scroll     = w_scroll;
        o_status.clr_last   = (r_clr_addr == AW'(DEPTH - 1));
        o_status.blank_last = (r_blank_col == COL_BITS'(COLUMNS - 1));
    end

    assign o_cursor_col = COL_W'(r_out_col);
    assign o_cursor_row = ROW_W'(r_out_row);
    assign o_scrolled   = r_out_scrolled;
    assign o_read_char  = r_out_rd;

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cell_writer.sv
// Text console cell writer: a ROWS by COLUMNS character store with a cursor
// and scrolling. Top level; depends on tcw_pkg, tcw_ifs, tcw_ctrl and tcw_dp.
//
// Usage:
//   i_in   takes one word per command: a character put or a cell read.
//   o_out  returns one word per command: cursor after the command, a scroll
//          flag and, for a read, the cell contents.
//   i_cfg  writes backspace code (index 0), enter code (1) and display
//          enable (2), always ready. Write it only while idle (not enforced).
// Timing: a word is handled one at a time. A plain put runs the exec and finish
//   states, a read adds a read wait for the registered store, and a put that
//   scrolls adds a blanking state that blanks the new bottom row one cell per
//   cycle through the single store write port. The result is registered and
//   shows on o_out the cycle after the command finishes.
// Reset: the cursor and scroll origin go to row 0, column 0 and the store is
//   filled with spaces, all ROWS * COLUMNS cells (2000 by default), during
//   which i_in is not ready.
// Stall: a finished result holds in the output register; the next word can be
//   accepted and worked, and its result waits until the register is taken.
`default_nettype none

module text_console_cell_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_out_if.source o_out,
    tcw_cfg_if.sink   i_cfg
);
    import tcw_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_item   w_item;
    logic    w_cfg_we;

    always_comb begin
        w_item.operation = i_in.operation;
        w_item.char_code = i_in.char_code;
        w_item.read_row  = i_in.read_row;
        w_item.read_col  = i_in.read_col;
    end

    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_item       (w_item),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_idx    (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_cursor_col (o_out.cursor_col),
        .o_cursor_row (o_out.cursor_row),
        .o_scrolled   (o_out.scrolled),
        .o_read_char  (o_out.read_char)
    );

`ifndef SYNTHESIS
    // Only one source may own the store write port in a cycle.
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr_we, w_cmd.blank_we, w_cmd.exec}))
        else $error("store write port claimed by more than one source");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_cmd.clr_we)
        else $error("input ready during the store clearing pass");

    // A scroll always leaves the cursor at column 0 of the last row.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.scrolled) |->
            (o_out.cursor_col == '0 && o_out.cursor_row == ROW_W'(ROWS - 1)))
        else $error("scrolled result with cursor off the last row start");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out.valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
